/* rtl/hue_brightness_rgb_pwm_unit_macros.svh */
// Assertion macros for the hue/brightness RGB PWM unit.
`ifndef HUE_BRIGHTNESS_RGB_PWM_UNIT_MACROS_SVH
`define HUE_BRIGHTNESS_RGB_PWM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define HBRP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbrp same-cycle check failed");
`define HBRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbrp next-cycle check failed");
`else
`define HBRP_ASSERT_SAME(lbl, ante, cons)
`define HBRP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/hbrp_pkg.sv */
// Shared types, constants and functions of the hue/brightness RGB PWM unit.
`timescale 1ns / 1ps
`default_nettype none
package hbrp_pkg;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int PIN_W  = 9;

  localparam logic [7:0] SECTOR_STEPS = 8'd42;
  localparam logic [7:0] WHEEL_PEAK   = 8'd252;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  led;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Full-saturation color wheel, 42 steps per sector; hue 0 is black.
  function automatic rgb_t wheel(logic [7:0] h);
    logic [2:0] sec;
    logic [7:0] base;
    logic [7:0] diff;
    logic [7:0] ramp;
    rgb_t       c;
    if (h >= 8'(6 * SECTOR_STEPS)) begin
      sec = 3'd0; base = 8'(6 * SECTOR_STEPS);
    end else if (h >= 8'(5 * SECTOR_STEPS)) begin
      sec = 3'd5; base = 8'(5 * SECTOR_STEPS);
    end else if (h >= 8'(4 * SECTOR_STEPS)) begin
      sec = 3'd4; base = 8'(4 * SECTOR_STEPS);
    end else if (h >= 8'(3 * SECTOR_STEPS)) begin
      sec = 3'd3; base = 8'(3 * SECTOR_STEPS);
    end else if (h >= 8'(2 * SECTOR_STEPS)) begin
      sec = 3'd2; base = 8'(2 * SECTOR_STEPS);
    end else if (h >= SECTOR_STEPS) begin
      sec = 3'd1; base = SECTOR_STEPS;
    end else begin
      sec = 3'd0; base = 8'd0;
    end
    diff = h - base;
    ramp = 8'(diff * 8'd6);
    case (sec)
      3'd0: c = '{r: WHEEL_PEAK,        g: ramp,              b: 8'd0};
      3'd1: c = '{r: WHEEL_PEAK - ramp, g: WHEEL_PEAK,        b: 8'd0};
      3'd2: c = '{r: 8'd0,              g: WHEEL_PEAK,        b: ramp};
      3'd3: c = '{r: 8'd0,              g: WHEEL_PEAK - ramp, b: WHEEL_PEAK};
      3'd4: c = '{r: ramp,              g: 8'd0,              b: WHEEL_PEAK};
      default: c = '{r: WHEEL_PEAK,     g: 8'd0,              b: WHEEL_PEAK - ramp};
    endcase
    if (h == 8'd0) begin
      c = '0;
    end
    return c;
  endfunction

  // Exact x/255 for x below 65280.
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

/* rtl/hue_brightness_rgb_pwm_unit.sv */
// Top level of the hue/brightness RGB PWM unit.
`timescale 1ns / 1ps
`default_nettype none
`include "hue_brightness_rgb_pwm_unit_macros.svh"
// Nine-channel PWM for three RGB LEDs. Each input word (tuser 0 = tick,
// 1 = set) yields one output word holding the pin levels before that word
// takes effect. A set maps hue onto a 252-step wheel, scales by brightness
// and loads the LED's shadow duties; a tick advances the 8-bit counter,
// reloads duties and raises all pins at wrap. Sustained rate is one word per
// clock while the output is ready; a word passes through the two front
// stages, the four-entry queue and the output register.
module hue_brightness_rgb_pwm_unit #(
  parameter int CHANNELS = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // led_index[1:0], hue[9:2], brightness[17:10]
  input  wire logic        in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // pin_levels[8:0]
);

  hbrp_pkg::qstat_t q_stat;
  hbrp_pkg::entry_t push_entry, pop_entry;
  logic             q_push, q_pop;
  logic [hbrp_pkg::PIN_W-1:0] pin_levels;

  hbrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cmd        (in_tuser),
    .led        (in_tdata[1:0]),
    .hue        (in_tdata[9:2]),
    .brightness (in_tdata[17:10]),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_entry (push_entry)
  );

  hbrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  hbrp_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_entry  (pop_entry),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pin_levels (pin_levels)
  );

  assign out_tdata = {7'd0, pin_levels};

  `HBRP_ASSERT_SAME(a_no_push_full, q_push, !q_stat.full)
  `HBRP_ASSERT_SAME(a_pop_room, q_pop, !q_stat.empty && (!out_tvalid || out_tready))
  `HBRP_ASSERT_NEXT(a_pop_shows, q_pop, out_tvalid)

endmodule
`default_nettype wire

/* rtl/hbrp_front.sv */
// Front end: accepts words, decodes the hue wheel and scales by brightness.
`timescale 1ns / 1ps
`default_nettype none
module hbrp_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           cmd,
  input  wire logic [1:0]     led,
  input  wire logic [7:0]     hue,
  input  wire logic [7:0]     brightness,
  input  wire hbrp_pkg::qstat_t q_stat,
  output logic                push,
  output hbrp_pkg::entry_t    push_entry
);

  logic             a_valid_r, a_valid_nxt;
  logic             a_cmd_r;
  logic [1:0]       a_led_r;
  hbrp_pkg::rgb_t   a_rgb_r;
  logic [7:0]       a_bri_r;
  logic             b_valid_r, b_valid_nxt;
  hbrp_pkg::entry_t b_entry_r;
  logic             a_ready, b_ready;

  assign push     = b_valid_r && !q_stat.full;
  assign b_ready  = !b_valid_r || !q_stat.full;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    a_valid_nxt = a_ready ? in_valid : a_valid_r;
    b_valid_nxt = b_ready ? a_valid_r : b_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_cmd_r <= cmd;
      a_led_r <= led;
      a_rgb_r <= hbrp_pkg::wheel(hue);
      a_bri_r <= brightness;
    end
    if (b_ready && a_valid_r) begin
      b_entry_r.cmd    <= a_cmd_r;
      b_entry_r.led    <= a_led_r;
      b_entry_r.prod_r <= a_rgb_r.r * a_bri_r;
      b_entry_r.prod_g <= a_rgb_r.g * a_bri_r;
      b_entry_r.prod_b <= a_rgb_r.b * a_bri_r;
    end
  end

  assign push_entry = b_entry_r;

endmodule
`default_nettype wire

/* rtl/hbrp_queue.sv */
// Short FIFO between the front end and the PWM back end.
`timescale 1ns / 1ps
`default_nettype none
module hbrp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire hbrp_pkg::entry_t push_entry,
  input  wire logic             pop,
  output hbrp_pkg::entry_t      pop_entry,
  output hbrp_pkg::qstat_t      q_stat
);

  hbrp_pkg::entry_t                  slot_r [hbrp_pkg::QDEPTH];
  logic [hbrp_pkg::QPTR_W-1:0]       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [hbrp_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == hbrp_pkg::QCNT_W'(hbrp_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_entry    = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + hbrp_pkg::QCNT_W'(push) - hbrp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* rtl/hbrp_back.sv */
// Back end: duty buffers, PWM counter, pin levels and the output register.
`timescale 1ns / 1ps
`default_nettype none
module hbrp_back #(
  parameter int CHANNELS = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hbrp_pkg::qstat_t q_stat,
  input  wire hbrp_pkg::entry_t pop_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [hbrp_pkg::PIN_W-1:0] pin_levels
);

  localparam int LED_MAX_RAW = (CHANNELS - 3) / 3;
  localparam logic [1:0] LED_LIMIT = 2'((LED_MAX_RAW > 2) ? 2 : LED_MAX_RAW);

  logic [7:0]          shadow_r [CHANNELS];
  logic [7:0]          shadow_nxt [CHANNELS];
  logic [7:0]          active_r [CHANNELS];
  logic [7:0]          active_nxt [CHANNELS];
  logic [7:0]          cnt_r, cnt_nxt;
  logic [CHANNELS-1:0] level_r, level_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [hbrp_pkg::PIN_W-1:0] out_data_r, pins;
  logic [7:0]          comp [3];
  logic                set_ok;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  for (genvar j = 0; j < hbrp_pkg::PIN_W; j++) begin : g_pins
    if (j < CHANNELS) begin : g_used
      assign pins[j] = level_r[j];
    end else begin : g_unused
      assign pins[j] = 1'b0;
    end
  end

  always_comb begin
    comp[0] = hbrp_pkg::div255(pop_entry.prod_r);
    comp[1] = hbrp_pkg::div255(pop_entry.prod_g);
    comp[2] = hbrp_pkg::div255(pop_entry.prod_b);
    set_ok  = (pop_entry.led <= LED_LIMIT);
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    level_nxt  = level_r;
    shadow_nxt = shadow_r;
    active_nxt = active_r;
    if (pop) begin
      if (pop_entry.cmd == hbrp_pkg::CMD_TICK) begin
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_nxt == 8'd0) begin
          active_nxt = shadow_r;
          level_nxt  = '1;
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (active_nxt[i] == cnt_nxt) begin
            level_nxt[i] = 1'b0;
          end
        end
      end else if (set_ok) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (i < 9 && pop_entry.led == 2'(i / 3)) begin
            shadow_nxt[i] = comp[i % 3];
          end
        end
      end
    end
    out_valid_nxt = pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        shadow_r[i] <= '0;
        active_r[i] <= '0;
      end
      cnt_r       <= 8'hFF;
      level_r     <= '1;
      out_valid_r <= 1'b0;
    end else begin
      shadow_r    <= shadow_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= pins;
    end
  end

  assign out_valid  = out_valid_r;
  assign pin_levels = out_data_r;

endmodule
`default_nettype wire
